// File: sv/rmp_pkg.sv
package rmp_pkg;

	// default width cap for counts (array count, bulk length)
	localparam int COUNT_BITS_DEF = 32;

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_BULK_LIMIT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ARRAY_LIMIT = CFG_IDX_W'(1);
	localparam logic [31:0] BULK_LIMIT_RST  = 32'd536870912;
	localparam logic [31:0] ARRAY_LIMIT_RST = 32'd1048576;

	// protocol characters
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [4:0] {
		ST_BEGIN      = 5'd0,
		ST_LINE_FIRST = 5'd1,
		ST_LINE       = 5'd2,
		ST_LINE_LF    = 5'd3,
		ST_CNT_FIRST  = 5'd4,
		ST_CNT        = 5'd5,
		ST_CNT_LF     = 5'd6,
		ST_ELEM       = 5'd7,
		ST_LEN_FIRST  = 5'd8,
		ST_LEN        = 5'd9,
		ST_LEN_LF     = 5'd10,
		ST_BODY       = 5'd11,
		ST_BODY_LF    = 5'd12,
		ST_ERROR      = 5'd13
	} parse_state_t;

	typedef enum logic [2:0] {
		EV_BUSY   = 3'd0,
		EV_BYTE   = 3'd1,
		EV_DONE   = 3'd2,
		EV_HEADER = 3'd3,
		EV_ERR    = 3'd4,
		EV_IDLE   = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		KIND_STATUS = 3'd0,
		KIND_ERROR  = 3'd1,
		KIND_INT    = 3'd2,
		KIND_BULK   = 3'd3,
		KIND_ARRAY  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [31:0] bulk_limit;
		logic [31:0] array_limit;
	} rmp_limits_t;

	typedef struct packed {
		event_t             event_res;
		logic [7:0]         payload_byte;
		kind_t              element_kind;
		logic [31:0]        element_length;
		logic signed [63:0] integer_value;
		logic               message_done;
	} rmp_result_t;

endpackage

// File: sv/rmp_byte_if.sv
interface rmp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// File: sv/rmp_result_if.sv
interface rmp_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_res;
	logic [7:0]         payload_byte;
	logic [2:0]         element_kind;
	logic [31:0]        element_length;
	logic signed [63:0] integer_value;
	logic               message_done;

	modport source (output valid, output event_res, output payload_byte,
		output element_kind, output element_length, output integer_value,
		output message_done, input ready);
	modport sink (input valid, input event_res, input payload_byte,
		input element_kind, input element_length, input integer_value,
		input message_done, output ready);
endinterface

// File: sv/rmp_cfg_if.sv
interface rmp_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/resp_message_parser.sv
// Byte-serial parser for a RESP-style line protocol. One byte is taken per beat on the
// stream channel and exactly one result beat leaves on the result channel for it, in order;
// the block sustains one byte per clock cycle while the result channel is ready; a byte passes
// from the input register through the combinational parse step into the result register before
// the result is offered. Results report payload bytes, finished elements (kind, length,
// integer value), array headers and message ends; any syntax error answers event 4 once and
// event 5 for every byte after it until reset. The limits (index 0 bulk length, index 1 array
// count) are written on the cfg channel, which is always ready, and should only change while
// no byte is in flight.
module resp_message_parser #(
	parameter int COUNT_BITS = rmp_pkg::COUNT_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	rmp_byte_if.sink      stream,
	rmp_result_if.source  result,
	rmp_cfg_if.sink       cfg
);
	import rmp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        res_valid_q;
	rmp_result_t res_q;
	rmp_result_t step_res;
	rmp_limits_t limits;
	logic        advance;

	// byte moves into the result register when that slot is free or drains
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	rmp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.limits (limits)
	);

	rmp_parser #(
		.COUNT_BITS (COUNT_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.limits  (limits),
		.res     (step_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.in_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.event_res      = res_q.event_res;
	assign result.payload_byte   = res_q.payload_byte;
	assign result.element_kind   = res_q.element_kind;
	assign result.element_length = res_q.element_length;
	assign result.integer_value  = res_q.integer_value;
	assign result.message_done   = res_q.message_done;

`ifndef SYNTHESIS
	// a held input byte is neither lost nor overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input byte lost while stalled");

	// a pending result is not replaced before it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |-> !advance)
		else $error("pending result overwritten");

	// the result slot empties only through a handshake
	a_res_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid_q) |-> $past(result.ready))
		else $error("result dropped without handshake");
`endif

endmodule

// File: sv/rmp_cfg_regs.sv
module rmp_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	rmp_cfg_if.sink            cfg,
	output rmp_pkg::rmp_limits_t limits
);
	import rmp_pkg::*;

	logic [31:0] bulk_limit_q;
	logic [31:0] array_limit_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bulk_limit_q  <= BULK_LIMIT_RST;
			array_limit_q <= ARRAY_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BULK_LIMIT:  bulk_limit_q  <= cfg.data;
				REG_ARRAY_LIMIT: array_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign limits.bulk_limit  = bulk_limit_q;
	assign limits.array_limit = array_limit_q;

endmodule

// File: sv/rmp_parser.sv
module rmp_parser #(
	parameter int COUNT_BITS = rmp_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           in_byte,
	input  rmp_pkg::rmp_limits_t limits,
	output rmp_pkg::rmp_result_t res
);
	import rmp_pkg::*;

	// largest count representable in COUNT_BITS bits
	localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

	parse_state_t state_q, state_d;
	kind_t        kind_q, kind_d;
	logic [31:0]  len_acc_q, len_acc_d;
	logic [31:0]  bulk_rem_q, bulk_rem_d;
	logic [31:0]  elem_rem_q, elem_rem_d;
	logic         in_array_q, in_array_d;
	logic [63:0]  int_acc_q, int_acc_d;
	logic         int_neg_q, int_neg_d;
	logic         int_stop_q, int_stop_d;
	logic [31:0]  pay_cnt_q, pay_cnt_d;

	logic        is_digit;
	logic [3:0]  dval;
	logic [31:0] lim_sel;
	logic [31:0] cap;
	logic [35:0] cnt_sum;
	logic        cnt_over;
	logic [63:0] int_next;
	logic [63:0] int_val;
	logic        err;

	// shared arithmetic: count digit, integer digit, signed value
	always_comb begin
		is_digit = in_byte inside {[CH_ZERO:CH_NINE]};
		dval     = 4'(in_byte - CH_ZERO);
		lim_sel  = (state_q == ST_CNT_FIRST || state_q == ST_CNT) ?
			limits.array_limit : limits.bulk_limit;
		cap      = ({32'b0, lim_sel} < CNT_MAX) ? lim_sel : CNT_MAX[31:0];
		cnt_sum  = {1'b0, len_acc_q, 3'b000} + {3'b000, len_acc_q, 1'b0} + {32'b0, dval};
		cnt_over = cnt_sum > {4'b0, cap};
		int_next = {int_acc_q[60:0], 3'b000} + {int_acc_q[62:0], 1'b0} + {60'b0, dval};
		int_val  = int_neg_q ? (64'd0 - int_acc_q) : int_acc_q;
	end

	// next state and element bookkeeping
	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		len_acc_d  = len_acc_q;
		bulk_rem_d = bulk_rem_q;
		elem_rem_d = elem_rem_q;
		in_array_d = in_array_q;
		int_acc_d  = int_acc_q;
		int_neg_d  = int_neg_q;
		int_stop_d = int_stop_q;
		pay_cnt_d  = pay_cnt_q;
		err        = 1'b0;
		case (state_q)
			ST_BEGIN: begin
				len_acc_d  = '0;
				pay_cnt_d  = '0;
				int_acc_d  = '0;
				int_neg_d  = 1'b0;
				int_stop_d = 1'b0;
				case (in_byte)
					CH_PLUS:   begin kind_d = KIND_STATUS; state_d = ST_LINE_FIRST; end
					CH_MINUS:  begin kind_d = KIND_ERROR;  state_d = ST_LINE_FIRST; end
					CH_COLON:  begin kind_d = KIND_INT;    state_d = ST_LINE_FIRST; end
					CH_DOLLAR: begin kind_d = KIND_BULK;   state_d = ST_LEN_FIRST;  end
					CH_STAR:   begin kind_d = KIND_ARRAY;  state_d = ST_CNT_FIRST;  end
					default:   err = 1'b1;
				endcase
			end
			ST_LINE_FIRST, ST_LINE: begin
				if (in_byte == CH_LF || (in_byte == CH_CR && state_q == ST_LINE_FIRST)) begin
					err = 1'b1;
				end else if (in_byte == CH_CR) begin
					state_d = ST_LINE_LF;
				end else begin
					state_d = ST_LINE;
					// integer value accumulation
					if (kind_q == KIND_INT && !int_stop_q) begin
						if (pay_cnt_q == '0 && in_byte == CH_MINUS) begin
							int_neg_d = 1'b1;
						end else if (is_digit) begin
							int_acc_d = int_next;
						end else begin
							int_stop_d = 1'b1;
						end
					end
					// saturating payload count
					if (pay_cnt_q != '1) begin
						pay_cnt_d = pay_cnt_q + 32'd1;
					end
				end
			end
			ST_LINE_LF: begin
				if (in_byte != CH_LF) begin
					err = 1'b1;
				end else begin
					state_d = ST_BEGIN;
				end
			end
			ST_CNT_FIRST, ST_CNT, ST_LEN_FIRST, ST_LEN: begin
				if (is_digit) begin
					if (cnt_over) begin
						err = 1'b1;
					end else begin
						len_acc_d = cnt_sum[31:0];
						state_d   = (state_q == ST_CNT_FIRST || state_q == ST_CNT) ?
							ST_CNT : ST_LEN;
					end
				end else if (in_byte == CH_CR && state_q == ST_CNT) begin
					state_d = ST_CNT_LF;
				end else if (in_byte == CH_CR && state_q == ST_LEN) begin
					state_d = ST_LEN_LF;
				end else begin
					err = 1'b1;
				end
			end
			ST_CNT_LF: begin
				if (in_byte != CH_LF) begin
					err = 1'b1;
				end else if (len_acc_q == '0) begin
					state_d = ST_BEGIN;
				end else begin
					elem_rem_d = len_acc_q;
					in_array_d = 1'b1;
					state_d    = ST_ELEM;
				end
			end
			ST_ELEM: begin
				if (in_byte != CH_DOLLAR) begin
					err = 1'b1;
				end else begin
					kind_d     = KIND_BULK;
					len_acc_d  = '0;
					pay_cnt_d  = '0;
					int_acc_d  = '0;
					int_neg_d  = 1'b0;
					int_stop_d = 1'b0;
					state_d    = ST_LEN_FIRST;
				end
			end
			ST_LEN_LF: begin
				if (in_byte != CH_LF) begin
					err = 1'b1;
				end else begin
					bulk_rem_d = len_acc_q;
					pay_cnt_d  = '0;
					state_d    = ST_BODY;
				end
			end
			ST_BODY: begin
				if (bulk_rem_q != '0) begin
					bulk_rem_d = bulk_rem_q - 32'd1;
					pay_cnt_d  = pay_cnt_q + 32'd1;
				end else if (in_byte == CH_CR) begin
					state_d = ST_BODY_LF;
				end else begin
					err = 1'b1;
				end
			end
			ST_BODY_LF: begin
				if (in_byte != CH_LF) begin
					err = 1'b1;
				end else if (in_array_q && elem_rem_q > 32'd1) begin
					elem_rem_d = elem_rem_q - 32'd1;
					state_d    = ST_ELEM;
				end else begin
					elem_rem_d = '0;
					in_array_d = 1'b0;
					state_d    = ST_BEGIN;
				end
			end
			ST_ERROR: ;
			default: err = 1'b1;
		endcase
		if (err) begin
			state_d = ST_ERROR;
		end
	end

	// result of the current beat
	always_comb begin
		res = '0;
		res.event_res    = EV_BUSY;
		res.element_kind = KIND_STATUS;
		case (state_q)
			ST_LINE_FIRST, ST_LINE: begin
				if (in_byte != CH_LF && in_byte != CH_CR) begin
					res.event_res    = EV_BYTE;
					res.payload_byte = in_byte;
					res.element_kind = kind_q;
				end
			end
			ST_LINE_LF: begin
				res.event_res      = EV_DONE;
				res.element_kind   = kind_q;
				res.element_length = pay_cnt_q;
				res.message_done   = 1'b1;
				if (kind_q == KIND_INT) begin
					res.integer_value = int_val;
				end
			end
			ST_CNT_LF: begin
				res.event_res      = EV_HEADER;
				res.element_kind   = KIND_ARRAY;
				res.element_length = len_acc_q;
				res.message_done   = (len_acc_q == '0);
			end
			ST_BODY: begin
				if (bulk_rem_q != '0) begin
					res.event_res    = EV_BYTE;
					res.payload_byte = in_byte;
					res.element_kind = KIND_BULK;
				end
			end
			ST_BODY_LF: begin
				res.event_res      = EV_DONE;
				res.element_kind   = KIND_BULK;
				res.element_length = pay_cnt_q;
				res.message_done   = !(in_array_q && elem_rem_q > 32'd1);
			end
			ST_ERROR: res.event_res = EV_IDLE;
			default: ;
		endcase
		// syntax error overrides everything
		if (err) begin
			res = '0;
			res.event_res    = EV_ERR;
			res.element_kind = KIND_STATUS;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_BEGIN;
			kind_q     <= KIND_STATUS;
			len_acc_q  <= '0;
			bulk_rem_q <= '0;
			elem_rem_q <= '0;
			in_array_q <= 1'b0;
			int_acc_q  <= '0;
			int_neg_q  <= 1'b0;
			int_stop_q <= 1'b0;
			pay_cnt_q  <= '0;
		end else if (step) begin
			state_q    <= state_d;
			kind_q     <= kind_d;
			len_acc_q  <= len_acc_d;
			bulk_rem_q <= bulk_rem_d;
			elem_rem_q <= elem_rem_d;
			in_array_q <= in_array_d;
			int_acc_q  <= int_acc_d;
			int_neg_q  <= int_neg_d;
			int_stop_q <= int_stop_d;
			pay_cnt_q  <= pay_cnt_d;
		end
	end

`ifndef SYNTHESIS
	// a syntax error is sticky
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ERROR |=> state_q == ST_ERROR)
		else $error("parser left error state");

	// inside an array there is always at least one element left
	a_array_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_array_q |-> elem_rem_q != '0)
		else $error("array flag set with no elements left");

	// message end only on element done or array header
	a_done_event: assert property (@(posedge clk) disable iff (!arst_n)
		res.message_done |-> (res.event_res == EV_DONE || res.event_res == EV_HEADER))
		else $error("message end on wrong event");

	// body byte count never runs past the bulk length
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BODY |-> pay_cnt_q <= len_acc_q)
		else $error("bulk body overran its length");
`endif

endmodule
